// ===== design/assert_macros.svh =====
// Assertion helpers: clocked property check and a never-true check.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define TKVT_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TKVT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define TKVT_ASSERT(label, clk, rst_n, prop, msg)
`define TKVT_NEVER(label, clk, rst_n, expr, msg)
`endif

`endif

// ===== design/tkvt_pkg.sv =====
package tkvt_pkg;

  localparam int BlobOffW = 6;
  localparam int BlobRoom = 64;

  typedef enum logic [1:0] {
    ActSet   = 2'd0,
    ActBlob  = 2'd1,
    ActRdId  = 2'd2,
    ActRdPos = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    StsOk      = 3'd0,
    StsNotFnd  = 3'd1,
    StsFull    = 3'd2,
    StsNoSlot  = 3'd3,
    StsSeq     = 3'd4
  } status_e;

  localparam logic [2:0] KindNone   = 3'd0;
  localparam logic [2:0] KindBool   = 3'd1;
  localparam logic [2:0] KindFloat  = 3'd4;
  localparam logic [2:0] KindString = 3'd5;
  localparam logic [2:0] KindBytes  = 3'd6;

  typedef enum logic [5:0] {
    StIdle = 6'b000001,
    StScan = 6'b000010,
    StCmp  = 6'b000100,
    StExec = 6'b001000,
    StBrd  = 6'b010000,
    StBout = 6'b100000
  } state_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] resource_id;
    logic [2:0]  value_kind;
    logic [31:0] scalar_value;
    logic [7:0]  blob_byte;
    logic [7:0]  blob_offset;
    logic [7:0]  blob_total;
    logic [5:0]  entry_position;
  } item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  kind_out;
    logic [31:0] id_out;
    logic [31:0] scalar_out;
    logic [5:0]  length_out;
    logic [7:0]  byte_out;
    logic [4:0]  byte_index_out;
    logic        last;
    logic [31:0] generation_out;
    logic [5:0]  count_out;
  } res_t;

  typedef struct packed {
    logic load;
    logic rd_ent;
    logic scan_inc;
    logic set_found;
    logic exec;
    logic rd_byte;
    logic emit_byte;
  } cmd_t;

  typedef struct packed {
    logic scan_end;
    logic hit;
    logic out_free;
    logic has_bytes;
    logic byte_last;
  } sts_t;

endpackage

// ===== design/tkvt_if.sv =====
interface tkvt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] resource_id;
  logic [2:0]  value_kind;
  logic [31:0] scalar_value;
  logic [7:0]  blob_byte;
  logic [7:0]  blob_offset;
  logic [7:0]  blob_total;
  logic [5:0]  entry_position;
  modport source (output valid, action, resource_id, value_kind, scalar_value, blob_byte,
                  blob_offset, blob_total, entry_position, input ready);
  modport sink (input valid, action, resource_id, value_kind, scalar_value, blob_byte,
                blob_offset, blob_total, entry_position, output ready);
endinterface

interface tkvt_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [2:0]  kind_out;
  logic [31:0] id_out;
  logic [31:0] scalar_out;
  logic [5:0]  length_out;
  logic [7:0]  byte_out;
  logic [4:0]  byte_index_out;
  logic        last;
  logic [31:0] generation_out;
  logic [5:0]  count_out;
  modport source (output valid, status, kind_out, id_out, scalar_out, length_out, byte_out,
                  byte_index_out, last, generation_out, count_out, input ready);
  modport sink (input valid, status, kind_out, id_out, scalar_out, length_out, byte_out,
                byte_index_out, last, generation_out, count_out, output ready);
endinterface

// ===== design/tkvt_ctrl.sv =====
`include "assert_macros.svh"

module tkvt_ctrl import tkvt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StScan;
        end
      end
      StScan: begin
        if (sts_i.scan_end) begin
          state_d = StExec;
        end else begin
          cmd_o.rd_ent = 1'b1;
          state_d      = StCmp;
        end
      end
      StCmp: begin
        if (sts_i.hit) begin
          cmd_o.set_found = 1'b1;
          state_d         = StExec;
        end else begin
          cmd_o.scan_inc = 1'b1;
          state_d        = StScan;
        end
      end
      StExec: begin
        if (sts_i.out_free) begin
          cmd_o.exec = 1'b1;
          state_d    = sts_i.has_bytes ? StBrd : StIdle;
        end
      end
      StBrd: begin
        cmd_o.rd_byte = 1'b1;
        state_d       = StBout;
      end
      StBout: begin
        if (sts_i.out_free) begin
          cmd_o.emit_byte = 1'b1;
          state_d         = sts_i.byte_last ? StIdle : StBrd;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  `TKVT_ASSERT(a_accept_scan, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> (state_q == StScan), "accepted item did not start a scan")
  `TKVT_NEVER(a_exec_blocked, clk_i, rst_ni, (cmd_o.exec || cmd_o.emit_byte) && !sts_i.out_free, "result loaded over a pending transfer")
  `TKVT_ASSERT(a_last_idle, clk_i, rst_ni, (cmd_o.emit_byte && sts_i.byte_last) |=> (state_q == StIdle), "final byte did not end the read")

endmodule

// ===== design/tkvt_dp.sv =====
`include "assert_macros.svh"

module tkvt_dp import tkvt_pkg::*; #(
  parameter int MAX_ENTRIES      = 32,
  parameter int MAX_BLOB_SLOTS   = 8,
  parameter int MAX_STRING_BYTES = 32,
  parameter int MAX_BINARY_BYTES = 32
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cmd_t  cmd_i,
  output sts_t  sts_o,
  input  item_t item_i,
  input  logic  out_ready_i,
  output logic  out_valid_o,
  output res_t  res_o
);

  localparam int EntW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CntW   = $clog2(MAX_ENTRIES + 1);
  localparam int SlotW  = (MAX_BLOB_SLOTS > 1) ? $clog2(MAX_BLOB_SLOTS) : 1;
  localparam int BlobAw = SlotW + BlobOffW;

  typedef struct packed {
    logic [31:0]      key;
    logic [2:0]       kind;
    logic [31:0]      scalar;
    logic             has_slot;
    logic [SlotW-1:0] slot;
    logic [5:0]       len;
  } rec_t;

  typedef struct packed {
    logic             active;
    logic [EntW-1:0]  entry;
    logic [SlotW-1:0] slot;
    logic [2:0]       kind;
    logic [7:0]       next;
    logic [7:0]       total;
  } pend_t;

  rec_t  ent_mem [MAX_ENTRIES];
  logic [7:0] blob_mem [MAX_BLOB_SLOTS * BlobRoom];

  item_t in_q;
  rec_t  rd_q;
  res_t  out_q;
  logic  out_valid_q;
  logic [EntW-1:0] ent_q;
  logic  found_q;
  logic [CntW-1:0] scan_q, cnt_q, cnt_d;
  logic [31:0] gen_q, gen_d;
  logic [MAX_BLOB_SLOTS-1:0] slot_use_q, slot_use_d;
  pend_t pend_q, pend_d;
  logic [BlobOffW-1:0] bidx_q;
  logic [7:0] bdata_q;

  logic [EntW-1:0]   rd_addr, tgt;
  logic              full, can_place, free_ok, match;
  logic [SlotW-1:0]  free_s;
  logic [7:0]        cap;
  rec_t              base, new_r, hrec;
  logic              hvalid, ent_we, blob_we;
  logic [BlobAw-1:0] blob_wa;
  logic [2:0]        st;
  logic [31:0]       hdr_id;
  logic [5:0]        hdr_len, rd_len;
  res_t              hdr;
  logic              is_rd;

  always_comb begin
    rd_addr = (in_q.action == ActRdPos) ? in_q.entry_position[EntW-1:0] : scan_q[EntW-1:0];
  end

  assign rd_len = ((rd_q.kind == KindString || rd_q.kind == KindBytes) && rd_q.has_slot)
                  ? rd_q.len : 6'd0;
  assign is_rd  = (in_q.action == ActRdId) || (in_q.action == ActRdPos);

  assign sts_o.scan_end  = (in_q.action == ActRdPos)
                           ? ({1'b0, in_q.entry_position} >= 7'(cnt_q))
                           : (scan_q == cnt_q);
  assign sts_o.hit       = (in_q.action == ActRdPos) || (rd_q.key == in_q.resource_id);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;
  assign sts_o.has_bytes = is_rd && found_q && (rd_len != 6'd0);
  assign sts_o.byte_last = ((7'(bidx_q) + 7'd1) == {1'b0, rd_len});

  always_comb begin
    full      = (cnt_q == CntW'(MAX_ENTRIES));
    can_place = found_q || !full;
    tgt       = found_q ? ent_q : cnt_q[EntW-1:0];
    cap       = (in_q.value_kind == KindString) ? 8'(MAX_STRING_BYTES) : 8'(MAX_BINARY_BYTES);
    free_ok   = 1'b0;
    free_s    = '0;
    for (int s = MAX_BLOB_SLOTS - 1; s >= 0; s--) begin
      if (!slot_use_q[s]) begin
        free_ok = 1'b1;
        free_s  = SlotW'(s);
      end
    end
    base = rd_q;
    if (!found_q) begin
      base     = '0;
      base.key = in_q.resource_id;
    end
    match = pend_q.active && found_q && (ent_q == pend_q.entry) &&
            (in_q.value_kind == pend_q.kind) && (in_q.blob_total == pend_q.total) &&
            (in_q.blob_offset == pend_q.next);

    new_r      = base;
    hrec       = rd_q;
    hvalid     = found_q;
    hdr_id     = in_q.resource_id;
    st         = StsOk;
    ent_we     = 1'b0;
    blob_we    = 1'b0;
    blob_wa    = '0;
    cnt_d      = cnt_q;
    gen_d      = gen_q;
    slot_use_d = slot_use_q;
    pend_d     = pend_q;

    case (action_e'(in_q.action))
      ActSet: begin
        if (in_q.value_kind < KindBool || in_q.value_kind > KindFloat) begin
          st = StsSeq;
        end else if (!can_place) begin
          st     = StsFull;
          hvalid = 1'b0;
        end else begin
          if (pend_q.active && pend_q.entry == tgt) pend_d.active = 1'b0;
          if (base.has_slot) slot_use_d[base.slot] = 1'b0;
          new_r.kind     = in_q.value_kind;
          new_r.scalar   = (in_q.value_kind == KindBool) ? {31'd0, |in_q.scalar_value}
                                                          : in_q.scalar_value;
          new_r.has_slot = 1'b0;
          new_r.slot     = '0;
          new_r.len      = '0;
          ent_we = 1'b1;
          hrec   = new_r;
          hvalid = 1'b1;
          gen_d  = gen_q + 32'd1;
          if (!found_q) cnt_d = cnt_q + CntW'(1);
        end
      end
      ActBlob: begin
        if (in_q.value_kind != KindString && in_q.value_kind != KindBytes) begin
          pend_d.active = 1'b0;
          st            = StsSeq;
        end else if (in_q.blob_offset == 8'd0) begin
          pend_d.active = 1'b0;
          if (!can_place) begin
            st     = StsFull;
            hvalid = 1'b0;
          end else begin
            if (!new_r.has_slot && free_ok) begin
              slot_use_d[free_s] = 1'b1;
              new_r.has_slot     = 1'b1;
              new_r.slot         = free_s;
            end
            if (!new_r.has_slot) begin
              st = StsNoSlot;
            end else if (in_q.blob_total == 8'd0) begin
              new_r.kind = in_q.value_kind;
              new_r.len  = 6'd0;
              gen_d      = gen_q + 32'd1;
            end else begin
              blob_we = 1'b1;
              blob_wa = {new_r.slot, BlobOffW'(0)};
              if (in_q.blob_total == 8'd1) begin
                new_r.kind = in_q.value_kind;
                new_r.len  = 6'd1;
                gen_d      = gen_q + 32'd1;
              end else begin
                pend_d.active = 1'b1;
                pend_d.entry  = tgt;
                pend_d.slot   = new_r.slot;
                pend_d.kind   = in_q.value_kind;
                pend_d.next   = 8'd1;
                pend_d.total  = in_q.blob_total;
              end
            end
            ent_we = 1'b1;
            hrec   = new_r;
            hvalid = 1'b1;
            if (!found_q) cnt_d = cnt_q + CntW'(1);
          end
        end else if (!match) begin
          pend_d.active = 1'b0;
          st            = StsSeq;
        end else begin
          if (in_q.blob_offset < cap) begin
            blob_we = 1'b1;
            blob_wa = {pend_q.slot, in_q.blob_offset[BlobOffW-1:0]};
          end
          if (({1'b0, in_q.blob_offset} + 9'd1) == {1'b0, in_q.blob_total}) begin
            new_r.kind    = in_q.value_kind;
            new_r.len     = (in_q.blob_total <= cap) ? in_q.blob_total[5:0] : cap[5:0];
            gen_d         = gen_q + 32'd1;
            pend_d.active = 1'b0;
            ent_we        = 1'b1;
          end else begin
            pend_d.next = in_q.blob_offset + 8'd1;
          end
          hrec = new_r;
        end
      end
      ActRdId, ActRdPos: begin
        if (!found_q) begin
          st     = StsNotFnd;
          hdr_id = (in_q.action == ActRdId) ? in_q.resource_id : 32'd0;
        end
      end
      default: begin
        st = StsSeq;
      end
    endcase

    hdr_len = ((hrec.kind == KindString || hrec.kind == KindBytes) && hrec.has_slot)
              ? hrec.len : 6'd0;
    hdr.status         = st;
    hdr.kind_out       = hvalid ? hrec.kind : KindNone;
    hdr.id_out         = hvalid ? hrec.key : hdr_id;
    hdr.scalar_out     = (hvalid && hrec.kind >= KindBool && hrec.kind <= KindFloat)
                         ? hrec.scalar : 32'd0;
    hdr.length_out     = hvalid ? hdr_len : 6'd0;
    hdr.byte_out       = 8'd0;
    hdr.byte_index_out = 5'd0;
    hdr.last           = !(is_rd && hvalid && hdr_len != 6'd0);
    hdr.generation_out = gen_d;
    hdr.count_out      = 6'(cnt_d);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_ent) rd_q <= ent_mem[rd_addr];
    if (cmd_i.exec && ent_we) ent_mem[tgt] <= new_r;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_byte) bdata_q <= blob_mem[{rd_q.slot, bidx_q}];
    if (cmd_i.exec && blob_we) blob_mem[blob_wa] <= in_q.blob_byte;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) in_q <= item_i;
    if (cmd_i.set_found) ent_q <= rd_addr;
    if (cmd_i.exec) begin
      out_q <= hdr;
    end else if (cmd_i.emit_byte) begin
      out_q.byte_out       <= bdata_q;
      out_q.byte_index_out <= bidx_q[4:0];
      out_q.last           <= sts_o.byte_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
      scan_q      <= '0;
      cnt_q       <= '0;
      gen_q       <= '0;
      slot_use_q  <= '0;
      pend_q      <= '0;
      bidx_q      <= '0;
    end else begin
      if (cmd_i.exec || cmd_i.emit_byte) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.load) begin
        found_q <= 1'b0;
        scan_q  <= '0;
      end
      if (cmd_i.scan_inc) scan_q <= scan_q + CntW'(1);
      if (cmd_i.set_found) found_q <= 1'b1;
      if (cmd_i.exec) begin
        cnt_q      <= cnt_d;
        gen_q      <= gen_d;
        slot_use_q <= slot_use_d;
        pend_q     <= pend_d;
        bidx_q     <= '0;
      end
      if (cmd_i.emit_byte) bidx_q <= bidx_q + BlobOffW'(1);
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = out_q;

  `TKVT_ASSERT(a_pend_entry, clk_i, rst_ni, pend_q.active |-> ({1'b0, pend_q.entry} < (EntW+1)'(cnt_q)), "pending write points past the entry list")

endmodule

// ===== design/typed_key_value_table.sv =====
// Channel  Dir  Handshake      Payload
// in_i     in   valid / ready  action, key, kind, scalar, blob byte, offset, total, position
// out_o    out  valid / ready  status, header fields, blob byte, index, last
//
// Each item scans the entry list, one entry at a time (a read by position visits only its
// entry), then applies the update and loads the result; a read then streams its blob bytes.
// Items are handled one at a time; input is taken only with the sequencer idle.
// Reset clears the entry count, generation, slot map and pending blob write; stores are
// not cleared.
// A stalled output holds the sequencer in place until the transfer completes.
module typed_key_value_table import tkvt_pkg::*; #(
  parameter int MAX_ENTRIES      = 32,
  parameter int MAX_BLOB_SLOTS   = 8,
  parameter int MAX_STRING_BYTES = 32,
  parameter int MAX_BINARY_BYTES = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tkvt_in_if.sink    in_i,
  tkvt_out_if.source out_o
);

  cmd_t  cmd;
  sts_t  sts;
  item_t item;
  res_t  res;
  logic  ready;

  assign item.action         = in_i.action;
  assign item.resource_id    = in_i.resource_id;
  assign item.value_kind     = in_i.value_kind;
  assign item.scalar_value   = in_i.scalar_value;
  assign item.blob_byte      = in_i.blob_byte;
  assign item.blob_offset    = in_i.blob_offset;
  assign item.blob_total     = in_i.blob_total;
  assign item.entry_position = in_i.entry_position;
  assign in_i.ready          = ready;

  tkvt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tkvt_dp #(
    .MAX_ENTRIES      (MAX_ENTRIES),
    .MAX_BLOB_SLOTS   (MAX_BLOB_SLOTS),
    .MAX_STRING_BYTES (MAX_STRING_BYTES),
    .MAX_BINARY_BYTES (MAX_BINARY_BYTES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .item_i      (item),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .res_o       (res)
  );

  assign out_o.status         = res.status;
  assign out_o.kind_out       = res.kind_out;
  assign out_o.id_out         = res.id_out;
  assign out_o.scalar_out     = res.scalar_out;
  assign out_o.length_out     = res.length_out;
  assign out_o.byte_out       = res.byte_out;
  assign out_o.byte_index_out = res.byte_index_out;
  assign out_o.last           = res.last;
  assign out_o.generation_out = res.generation_out;
  assign out_o.count_out      = res.count_out;

endmodule
